/* src/lcd_pkg.sv */
package lcd_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int COORD_W     = 6;
    localparam int COUNT_W     = 4;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 1'b1;

    localparam logic [CFG_W-1:0] BIRTH_RST   = 4'd3;
    localparam logic [CFG_W-1:0] SURVIVE_RST = 4'd2;

    typedef struct packed {
        logic up;
        logic mid;
    } t_eval_ctl;

endpackage

/* src/lcd_row_mem.sv */
module lcd_row_mem
    import lcd_pkg::*;
#(
    parameter int DEPTH = GRID_HEIGHT_DEF,
    parameter int WIDTH = GRID_WIDTH_DEF,
    parameter int AW    = $clog2(GRID_HEIGHT_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lcd_eval.sv */
module lcd_eval
    import lcd_pkg::*;
#(
    parameter int GRID_WIDTH = GRID_WIDTH_DEF,
    parameter int XW         = $clog2(GRID_WIDTH_DEF)
) (
    input  logic                  i_clk,
    input  logic [GRID_WIDTH-1:0] i_row,
    input  logic [XW-1:0]         i_xl,
    input  logic [XW-1:0]         i_x,
    input  logic [XW-1:0]         i_xr,
    input  t_eval_ctl             i_ctl,
    input  logic [CFG_W-1:0]      i_birth,
    input  logic [CFG_W-1:0]      i_survive,
    output logic [COUNT_W-1:0]    o_count,
    output logic                  o_next,
    output logic                  o_changes
);

    logic [2:0] r_acc;
    logic       r_now;
    logic [1:0] w_sum3;
    logic [1:0] w_sum2;

    assign w_sum3 = {1'b0, i_row[i_xl]} + {1'b0, i_row[i_x]} + {1'b0, i_row[i_xr]};
    assign w_sum2 = {1'b0, i_row[i_xl]} + {1'b0, i_row[i_xr]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.up) begin
            r_acc <= {1'b0, w_sum3};
        end else if (i_ctl.mid) begin
            r_acc <= r_acc + {1'b0, w_sum2};
            r_now <= i_row[i_x];
        end
    end

    // bottom row is summed on the fly
    assign o_count = {1'b0, r_acc} + {2'b00, w_sum3};

    always_comb begin
        priority if (o_count == i_birth) begin
            o_next = 1'b1;
        end else if (o_count == i_survive) begin
            o_next = r_now;
        end else begin
            o_next = 1'b0;
        end
    end

    assign o_changes = o_next ^ r_now;

endmodule

/* src/life_cell_change_detector_top.sv */
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: cell_x, cell_y, alive; tuser: op
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: changes, next_alive, live_neighbors
// cfg       in   i_cfg_we                         i_cfg_index, i_cfg_wdata
//
// Evaluate: three row reads through the single read port of the row memory
// (row above, own row, row below); the next transaction can be accepted in the last step.
// Write: read row then write it back with one bit replaced.
// After reset the memory is cleared one row a cycle, all GRID_HEIGHT rows, with
// s_axis held off; configuration writes are taken at any time.
// A stalled m_axis holds an evaluation in its last step until the result slot frees.
module life_cell_change_detector_top
    import lcd_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // cell_x[5:0], cell_y[11:6], alive[12]
    input  logic                   i_s_axis_tuser,  // op
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // changes[0], next_alive[1], live_neighbors[5:2]
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int NCOORD = 2 ** COORD_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_UP   = 3'd2;
    localparam logic [2:0] ST_MID  = 3'd3;
    localparam logic [2:0] ST_DN   = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [YW-1:0]   r_clr_row;
    logic [CFG_W-1:0] r_birth, r_survive;

    logic [XW-1:0]   r_x, r_xl, r_xr;
    logic [YW-1:0]   r_y, r_yd;
    logic            r_alive;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [XW-1:0]   w_xmod [NCOORD];
    logic [YW-1:0]   w_ymod [NCOORD];
    logic [XW-1:0]   w_in_x, w_in_xl, w_in_xr;
    logic [YW-1:0]   w_in_y, w_in_yu, w_in_yd;
    logic            w_in_acc;
    logic            w_out_free;

    logic                  w_we, w_re;
    logic [YW-1:0]         w_waddr, w_raddr;
    logic [GRID_WIDTH-1:0] w_wdata, w_rdata, w_mod_row;

    t_eval_ctl             w_ctl;
    logic [COUNT_W-1:0]    w_count;
    logic                  w_next, w_changes;

    for (genvar i = 0; i < NCOORD; i++) begin : g_mod
        assign w_xmod[i] = XW'(i % GRID_WIDTH);
        assign w_ymod[i] = YW'(i % GRID_HEIGHT);
    end

    assign w_in_x  = w_xmod[i_s_axis_tdata[COORD_W-1:0]];
    assign w_in_y  = w_ymod[i_s_axis_tdata[2*COORD_W-1:COORD_W]];
    assign w_in_xl = (w_in_x == '0) ? XW'(GRID_WIDTH - 1) : w_in_x - 1'b1;
    assign w_in_xr = (w_in_x == XW'(GRID_WIDTH - 1)) ? '0 : w_in_x + 1'b1;
    assign w_in_yu = (w_in_y == '0) ? YW'(GRID_HEIGHT - 1) : w_in_y - 1'b1;
    assign w_in_yd = (w_in_y == YW'(GRID_HEIGHT - 1)) ? '0 : w_in_y + 1'b1;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) || ((r_state == ST_DN) && w_out_free);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= BIRTH_RST;
            r_survive <= SURVIVE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BIRTH:   r_birth   <= i_cfg_wdata;
                REG_SURVIVE: r_survive <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr_row == YW'(GRID_HEIGHT - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc) n_state = (i_s_axis_tuser == OP_WRITE) ? ST_WR : ST_UP;
            end
            ST_UP:  n_state = ST_MID;
            ST_MID: n_state = ST_DN;
            ST_DN: begin
                if (w_in_acc) begin
                    n_state = (i_s_axis_tuser == OP_WRITE) ? ST_WR : ST_UP;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WR:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x     <= w_in_x;
            r_xl    <= w_in_xl;
            r_xr    <= w_in_xr;
            r_y     <= w_in_y;
            r_yd    <= w_in_yd;
            r_alive <= i_s_axis_tdata[2*COORD_W];
        end
    end

    // memory port control
    always_comb begin
        w_mod_row        = w_rdata;
        w_mod_row[r_x]   = r_alive;
        w_we    = 1'b0;
        w_waddr = r_y;
        w_wdata = w_mod_row;
        if (r_state == ST_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_row;
            w_wdata = '0;
        end else if (r_state == ST_WR) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_y;
        priority if (w_in_acc) begin
            w_re    = 1'b1;
            w_raddr = (i_s_axis_tuser == OP_WRITE) ? w_in_y : w_in_yu;
        end else if (r_state == ST_UP) begin
            w_re    = 1'b1;
            w_raddr = r_y;
        end else if (r_state == ST_MID) begin
            w_re    = 1'b1;
            w_raddr = r_yd;
        end else begin
            w_re    = 1'b0;
        end
    end

    assign w_ctl.up  = (r_state == ST_UP);
    assign w_ctl.mid = (r_state == ST_MID);

    lcd_row_mem #(
        .DEPTH (GRID_HEIGHT),
        .WIDTH (GRID_WIDTH),
        .AW    (YW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lcd_eval #(
        .GRID_WIDTH (GRID_WIDTH),
        .XW         (XW)
    ) u_eval (
        .i_clk     (i_clk),
        .i_row     (w_rdata),
        .i_xl      (r_xl),
        .i_x       (r_x),
        .i_xr      (r_xr),
        .i_ctl     (w_ctl),
        .i_birth   (r_birth),
        .i_survive (r_survive),
        .o_count   (w_count),
        .o_next    (w_next),
        .o_changes (w_changes)
    );

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DN) && w_out_free) begin
            r_out_data <= {2'b00, w_count, w_next, w_changes};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_s_axis_tready)
        else $error("input taken during memory clear");

    a_result_from_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == ST_DN))
        else $error("result loaded outside final evaluation step");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[5:2] <= 4'd8))
        else $error("neighbor count above eight");

    a_wr_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> $past(w_in_acc && (i_s_axis_tuser == OP_WRITE)))
        else $error("row write-back without a write transaction");

endmodule
